// File: hdl/ghb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghb_pkg
// Shared constants, types and calendar helpers for the hours-between block.
// ----------------------------------------------------------------------------
package ghb_pkg;

  // Default field widths
  localparam int unsigned YEAR_WIDTH_DEF     = 12;
  localparam int unsigned HOUR_FRAC_BITS_DEF = 12;
  localparam int unsigned MONTH_W            = 4;
  localparam int unsigned DAY_W              = 5;
  localparam int unsigned MONTH_OFF_W        = 9;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned HOURS_PER_DAY = 24;

  // Pipeline stage enables, one per register stage
  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
    logic en_d;
    logic en_e;
  } ghb_ctrl_t;

  // Force month into January..December
  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    r = m;
    if (m < MONTH_JAN) r = MONTH_JAN;
    else if (m > MONTH_DEC) r = MONTH_DEC;
    return r;
  endfunction

  // Days in a common year before the month with zero-based index idx
  function automatic logic [MONTH_OFF_W-1:0] days_before_month(input logic [MONTH_W-1:0] idx);
    logic [MONTH_OFF_W-1:0] r;
    unique case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/gregorian_hours_between_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_hours_between_unit
// Hours elapsed between two calendar moments, Gregorian leap-year rule.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one transaction carries a start and an end moment
//   (year, month, day, fixed-point hour). Output stream (m_axis_*): one
//   transaction per input with the elapsed hours in tdata and the
//   start-after-end flag in tuser; a flagged result carries zero hours.
//   Throughput: one transaction per cycle, sustained while m_axis_tready stays high.
//   Pipeline: five register stages. The stages are the year / 100 reciprocal
//   multiply, the leap count and month offset, the day-number sum, the day and
//   hour differences, and the scaling to hours with the output register.
//   Each stage has its own valid bit and loads when it is empty or the stage
//   after it moves, so a stall on m_axis_tready fills empty stages first and
//   then drops s_axis_tready; nothing is lost or repeated.
//   Reset clears all valid bits; no transaction is presented until new input.
// ----------------------------------------------------------------------------
module gregorian_hours_between_unit import ghb_pkg::*; #(
  parameter int unsigned YEAR_WIDTH     = YEAR_WIDTH_DEF,
  parameter int unsigned HOUR_FRAC_BITS = HOUR_FRAC_BITS_DEF,
  localparam int unsigned HOUR_W       = HOUR_FRAC_BITS + 5,
  localparam int unsigned ELA_W        = YEAR_WIDTH + HOUR_FRAC_BITS + 14,
  localparam int unsigned IN_W         = 2 * ELA_W,
  localparam int unsigned IN_TDATA_W   = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W  = ((ELA_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // start_year, start_month, start_day, start_hour,
  // end_year, end_month, end_day, end_hour (lowest bit first), zero padded
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // elapsed_hours, zero padded
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // start_after_end
  output logic                   m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready
);

  localparam int unsigned OFF_MON  = YEAR_WIDTH;
  localparam int unsigned OFF_DAY  = YEAR_WIDTH + MONTH_W;
  localparam int unsigned OFF_HOUR = YEAR_WIDTH + MONTH_W + DAY_W;
  localparam int unsigned OFF_END  = ELA_W;
  localparam int unsigned KEY_W    = YEAR_WIDTH + MONTH_W + DAY_W + HOUR_W;

  // Unpack the input transaction
  logic [YEAR_WIDTH-1:0] ys, ye;
  logic [MONTH_W-1:0]    ms, me;
  logic [DAY_W-1:0]      ds, de;
  logic [HOUR_W-1:0]     hs, he;
  logic [KEY_W-1:0]      key_s, key_e;
  logic                  after;

  always_comb begin
    ys    = s_axis_tdata[0 +: YEAR_WIDTH];
    ms    = clamp_month(s_axis_tdata[OFF_MON +: MONTH_W]);
    ds    = s_axis_tdata[OFF_DAY +: DAY_W];
    hs    = s_axis_tdata[OFF_HOUR +: HOUR_W];
    ye    = s_axis_tdata[OFF_END +: YEAR_WIDTH];
    me    = clamp_month(s_axis_tdata[OFF_END + OFF_MON +: MONTH_W]);
    de    = s_axis_tdata[OFF_END + OFF_DAY +: DAY_W];
    he    = s_axis_tdata[OFF_END + OFF_HOUR +: HOUR_W];
    // year, month, day, hour order equals one compare of the joined fields
    key_s = {ys, ms, ds, hs};
    key_e = {ye, me, de, he};
    after = key_s > key_e;
  end

  // Stage enables and valid bits
  logic      v_a_q, v_b_q, v_c_q, v_d_q, v_e_q;
  logic      v_a_d, v_b_d, v_c_d, v_d_d, v_e_d;
  ghb_ctrl_t ctrl;

  always_comb begin
    ctrl.en_e = !v_e_q || m_axis_tready;
    ctrl.en_d = !v_d_q || ctrl.en_e;
    ctrl.en_c = !v_c_q || ctrl.en_d;
    ctrl.en_b = !v_b_q || ctrl.en_c;
    ctrl.en_a = !v_a_q || ctrl.en_b;
    v_a_d = ctrl.en_a ? s_axis_tvalid : v_a_q;
    v_b_d = ctrl.en_b ? v_a_q : v_b_q;
    v_c_d = ctrl.en_c ? v_b_q : v_c_q;
    v_d_d = ctrl.en_d ? v_c_q : v_d_q;
    v_e_d = ctrl.en_e ? v_d_q : v_e_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
    end else begin
      v_a_q <= v_a_d;
      v_b_q <= v_b_d;
      v_c_q <= v_c_d;
      v_d_q <= v_d_d;
      v_e_q <= v_e_d;
    end
  end

  // Carry the order flag and hours alongside the day-number stages
  logic              after_a_q, after_b_q, after_c_q;
  logic [HOUR_W-1:0] hs_a_q, hs_b_q, hs_c_q;
  logic [HOUR_W-1:0] he_a_q, he_b_q, he_c_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.en_a) begin
      after_a_q <= after;
      hs_a_q    <= hs;
      he_a_q    <= he;
    end
    if (ctrl.en_b) begin
      after_b_q <= after_a_q;
      hs_b_q    <= hs_a_q;
      he_b_q    <= he_a_q;
    end
    if (ctrl.en_c) begin
      after_c_q <= after_b_q;
      hs_c_q    <= hs_b_q;
      he_c_q    <= he_b_q;
    end
  end

  // Day numbers of both moments
  logic [YEAR_WIDTH+8:0] dn_s, dn_e;

  ghb_daynum #(
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_daynum_start (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .year_i    (ys),
    .month_i   (ms),
    .day_i     (ds),
    .day_num_o (dn_s)
  );

  ghb_daynum #(
    .YEAR_WIDTH (YEAR_WIDTH)
  ) u_daynum_end (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .year_i    (ye),
    .month_i   (me),
    .day_i     (de),
    .day_num_o (dn_e)
  );

  // Difference, scaling and output register
  logic [ELA_W-1:0] elapsed;
  logic             flag;

  ghb_span #(
    .YEAR_WIDTH     (YEAR_WIDTH),
    .HOUR_FRAC_BITS (HOUR_FRAC_BITS)
  ) u_span (
    .clk_i           (clk_i),
    .ctrl_i          (ctrl),
    .after_i         (after_c_q),
    .hour_start_i    (hs_c_q),
    .hour_end_i      (he_c_q),
    .day_num_start_i (dn_s),
    .day_num_end_i   (dn_e),
    .elapsed_o       (elapsed),
    .after_o         (flag)
  );

  assign s_axis_tready = ctrl.en_a;
  assign m_axis_tvalid = v_e_q;
  assign m_axis_tdata  = OUT_TDATA_W'(elapsed);
  assign m_axis_tuser  = flag;

endmodule

// File: hdl/ghb_daynum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghb_daynum
// Three-stage day-number pipeline: days before the year, before the month,
// plus the day field, under the Gregorian leap-year rule.
// ----------------------------------------------------------------------------
module ghb_daynum import ghb_pkg::*; #(
  parameter int unsigned YEAR_WIDTH = YEAR_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  ghb_ctrl_t               ctrl_i,
  input  logic [YEAR_WIDTH-1:0]   year_i,
  input  logic [MONTH_W-1:0]      month_i,    // already clamped to 1..12
  input  logic [DAY_W-1:0]        day_i,
  output logic [YEAR_WIDTH+8:0]   day_num_o
);

  localparam int unsigned DN_W      = YEAR_WIDTH + 9;
  localparam int unsigned SHIFT     = YEAR_WIDTH + 8;
  localparam int unsigned RECIP_W   = YEAR_WIDTH + 2;
  localparam int unsigned PROD_W    = YEAR_WIDTH + RECIP_W;
  localparam int unsigned Q_W       = YEAR_WIDTH - 6;
  localparam int unsigned RECIP100  = ((32'd1 << SHIFT) + 32'd99) / 32'd100;

  // Stage A: reciprocal multiply for year / 100
  logic [YEAR_WIDTH-1:0] year_a_q;
  logic [MONTH_W-1:0]    mon_a_q;
  logic [DAY_W-1:0]      day_a_q;
  logic [PROD_W-1:0]     prod_a_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_a) begin
      year_a_q <= year_i;
      mon_a_q  <= month_i;
      day_a_q  <= day_i;
      prod_a_q <= PROD_W'(year_i) * PROD_W'(RECIP_W'(RECIP100));
    end
  end

  // Stage B: remainder, leap test, leap count, year and month offsets
  logic [Q_W-1:0]          quo;
  logic [YEAR_WIDTH-1:0]   rem_full;
  logic                    rem_nz;
  logic                    leap;
  logic [YEAR_WIDTH:0]     year_p3;
  logic [YEAR_WIDTH-1:0]   ceil4, ceil100, ceil400, leaps;
  logic [DN_W-1:0]         base_d;
  logic [MONTH_OFF_W-1:0]  off_d;

  always_comb begin
    quo      = prod_a_q[PROD_W-1:SHIFT];
    rem_full = year_a_q - YEAR_WIDTH'(YEAR_WIDTH'(quo) * YEAR_WIDTH'(100));
    rem_nz   = (rem_full[6:0] != 7'd0);
    leap     = ((year_a_q[1:0] == 2'd0) && rem_nz) || (!rem_nz && (quo[1:0] == 2'd0));
    year_p3  = (YEAR_WIDTH+1)'(year_a_q) + (YEAR_WIDTH+1)'(3);
    ceil4    = YEAR_WIDTH'(year_p3 >> 2);
    ceil100  = YEAR_WIDTH'(quo) + YEAR_WIDTH'(rem_nz);
    ceil400  = YEAR_WIDTH'(quo >> 2) + YEAR_WIDTH'((quo[1:0] != 2'd0) || rem_nz);
    leaps    = ceil4 - ceil100 + ceil400;
    base_d   = DN_W'(year_a_q) * DN_W'(DAYS_PER_YEAR);
    off_d    = days_before_month(mon_a_q - MONTH_JAN)
             + MONTH_OFF_W'((mon_a_q > MONTH_FEB) && leap);
  end

  logic [DN_W-1:0]        base_b_q;
  logic [YEAR_WIDTH-1:0]  leaps_b_q;
  logic [MONTH_OFF_W-1:0] off_b_q;
  logic [DAY_W-1:0]       day_b_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_b) begin
      base_b_q  <= base_d;
      leaps_b_q <= leaps;
      off_b_q   <= off_d;
      day_b_q   <= day_a_q;
    end
  end

  // Stage C: sum the parts into the day number
  logic [DN_W-1:0] dn_c_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_c) begin
      dn_c_q <= base_b_q + DN_W'(leaps_b_q) + DN_W'(off_b_q) + DN_W'(day_b_q);
    end
  end

  assign day_num_o = dn_c_q;

endmodule

// File: hdl/ghb_span.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghb_span
// Final two stages: day and hour differences, then scaling to fixed-point
// hours with the negative-result check and the output register.
// ----------------------------------------------------------------------------
module ghb_span import ghb_pkg::*; #(
  parameter int unsigned YEAR_WIDTH     = YEAR_WIDTH_DEF,
  parameter int unsigned HOUR_FRAC_BITS = HOUR_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  ghb_ctrl_t                              ctrl_i,
  input  logic                                   after_i,
  input  logic [HOUR_FRAC_BITS+4:0]              hour_start_i,
  input  logic [HOUR_FRAC_BITS+4:0]              hour_end_i,
  input  logic [YEAR_WIDTH+8:0]                  day_num_start_i,
  input  logic [YEAR_WIDTH+8:0]                  day_num_end_i,
  output logic [YEAR_WIDTH+HOUR_FRAC_BITS+13:0]  elapsed_o,
  output logic                                   after_o
);

  localparam int unsigned HOUR_W = HOUR_FRAC_BITS + 5;
  localparam int unsigned DN_W   = YEAR_WIDTH + 9;
  localparam int unsigned D24_W  = DN_W + 6;
  localparam int unsigned ELA_W  = YEAR_WIDTH + HOUR_FRAC_BITS + 14;
  localparam int unsigned TOT_W  = ELA_W + 1;

  // Stage D: signed day and hour differences
  logic signed [DN_W:0]   days_d_q;
  logic signed [HOUR_W:0] hdiff_d_q;
  logic                   after_d_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_d) begin
      days_d_q  <= $signed({1'b0, day_num_end_i}) - $signed({1'b0, day_num_start_i});
      hdiff_d_q <= $signed({1'b0, hour_end_i}) - $signed({1'b0, hour_start_i});
      after_d_q <= after_i;
    end
  end

  // Stage E: scale days by 24 hours and the fraction, add hour difference
  logic signed [D24_W-1:0] days24;
  logic signed [TOT_W-1:0] total;
  logic                    bad;

  always_comb begin
    days24 = (D24_W'(days_d_q) <<< 4) + (D24_W'(days_d_q) <<< 3);
    total  = (TOT_W'(days24) <<< HOUR_FRAC_BITS) + TOT_W'(hdiff_d_q);
    bad    = after_d_q || total[TOT_W-1];
  end

  logic [ELA_W-1:0] elapsed_e_q;
  logic             after_e_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_e) begin
      elapsed_e_q <= bad ? '0 : total[ELA_W-1:0];
      after_e_q   <= bad;
    end
  end

  assign elapsed_o = elapsed_e_q;
  assign after_o   = after_e_q;

endmodule

// File: tb/elapsed_hours_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elapsed_hours_checker
// Scoreboard for the hours-between unit. Watches the input and output stream
// channels and works out the hours for every accepted date pair. Compares
// each result transaction, field by field, with the oldest outstanding
// prediction. Hands the mismatch count and the outstanding count to the top.
// ----------------------------------------------------------------------------
module elapsed_hours_checker import ghb_pkg::*; #(
  localparam int unsigned YEAR_W      = YEAR_WIDTH_DEF,
  localparam int unsigned HOUR_W      = HOUR_FRAC_BITS_DEF + 5,
  localparam int unsigned MOMENT_W    = YEAR_W + MONTH_W + DAY_W + HOUR_W,
  localparam int unsigned ELAPSED_W   = YEAR_WIDTH_DEF + HOUR_FRAC_BITS_DEF + 14,
  localparam int unsigned IN_TDATA_W  = ((2 * MOMENT_W + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W = ((ELAPSED_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // start_year, start_month, start_day, start_hour,
  // end_year, end_month, end_day, end_hour (lowest bit first), zero padded
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  // elapsed_hours, zero padded
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  // start_after_end
  input  logic                   m_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  output int                     mismatch_count_o,
  output int                     outstanding_o
);

  localparam longint HOUR_ONE    = longint'(1) << HOUR_FRAC_BITS_DEF;
  localparam int     MAX_REPORTS = 10;

  // One calendar moment, year in the lowest bits
  typedef struct packed {
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } moment_t;

  // Predicted result together with the date pair that caused it
  typedef struct {
    moment_t              start_m;
    moment_t              end_m;
    logic [ELAPSED_W-1:0] hours;
    logic                 late;
  } span_t;

  span_t expected_spans[$];
  span_t want;
  int    mismatches;

  // Months outside January..December count as the nearest end
  function automatic int unsigned clamped_month(input logic [MONTH_W-1:0] m);
    if (m < MONTH_JAN) return MONTH_JAN;
    if (m > MONTH_DEC) return MONTH_DEC;
    return m;
  endfunction

  function automatic bit leap_year(input longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Leap years from year zero up to, not including, y
  function automatic longint leaps_prior(input longint y);
    if (y == 0) return 0;
    return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic int month_length(input int m);
    case (m)
      2:             return 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Days from a fixed origin; the day field is taken as given
  function automatic longint day_index(input moment_t t);
    longint n;
    int     mon;
    mon = clamped_month(t.month);
    n = longint'(DAYS_PER_YEAR) * longint'(t.year) + leaps_prior(longint'(t.year));
    for (int k = 1; k < mon; k++) n += month_length(k);
    if (mon > MONTH_FEB && leap_year(longint'(t.year))) n += 1;
    n += longint'(t.day);
    return n;
  endfunction

  // Hours from start to end, or the late flag with zero hours
  function automatic span_t hours_between(input moment_t s, input moment_t e);
    span_t  r;
    int     ms;
    int     me;
    bit     late;
    longint total;
    ms = clamped_month(s.month);
    me = clamped_month(e.month);
    if (s.year != e.year)   late = s.year > e.year;
    else if (ms != me)      late = ms > me;
    else if (s.day != e.day) late = s.day > e.day;
    else                    late = s.hour > e.hour;
    total = (day_index(e) - day_index(s)) * longint'(HOURS_PER_DAY) * HOUR_ONE
            + longint'(e.hour) - longint'(s.hour);
    r.start_m = s;
    r.end_m   = e;
    if (late || total < 0) begin
      r.hours = '0;
      r.late  = 1'b1;
    end else begin
      r.hours = total[ELAPSED_W-1:0];
      r.late  = 1'b0;
    end
    return r;
  endfunction

  // Compare results first, then record the transaction accepted at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_spans.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_spans.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected result: hours %0d late %0b", $time,
                     m_tdata_i[ELAPSED_W-1:0], m_tuser_i);
          mismatches++;
        end else begin
          want = expected_spans.pop_front();
          if (m_tdata_i[ELAPSED_W-1:0] !== want.hours || m_tuser_i !== want.late) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: %0d-%0d-%0d h%0d -> %0d-%0d-%0d h%0d: expected %0d/%0b got %0d/%0b",
                       $time, want.start_m.year, want.start_m.month, want.start_m.day,
                       want.start_m.hour, want.end_m.year, want.end_m.month,
                       want.end_m.day, want.end_m.hour, want.hours, want.late,
                       m_tdata_i[ELAPSED_W-1:0], m_tuser_i);
            mismatches++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_spans.push_back(hours_between(moment_t'(s_tdata_i[MOMENT_W-1:0]),
                                               moment_t'(s_tdata_i[2*MOMENT_W-1:MOMENT_W])));
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= expected_spans.size();
  end

endmodule

// File: tb/tb_gregorian_hours_between_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_hours_between_unit
// Stimulus and verdict for the hours-between unit. Drives directed date pairs
// (field extremes, leap rules, clamped months, invalid days, oversized hours)
// and then random pairs, mostly ordered dates, with random idle cycles on
// both stream sides, a long output stall and full drains between phases.
// ----------------------------------------------------------------------------
module tb_gregorian_hours_between_unit import ghb_pkg::*; ();

  localparam int unsigned YEAR_W       = YEAR_WIDTH_DEF;
  localparam int unsigned HOUR_W       = HOUR_FRAC_BITS_DEF + 5;
  localparam int unsigned MOMENT_W     = YEAR_W + MONTH_W + DAY_W + HOUR_W;
  localparam int unsigned ELAPSED_W    = YEAR_WIDTH_DEF + HOUR_FRAC_BITS_DEF + 14;
  localparam int unsigned IN_TDATA_W   = ((2 * MOMENT_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((ELAPSED_W + 7) / 8) * 8;
  localparam int unsigned YEAR_MAX     = (1 << YEAR_W) - 1;
  localparam int unsigned HOUR_MAX     = (1 << HOUR_W) - 1;
  localparam int unsigned DAY_FULL     = HOURS_PER_DAY << HOUR_FRAC_BITS_DEF;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_ITEMS = 1026;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_BURST   = 40;
  localparam int          LONG_HOLD    = 200;
  localparam int          DRAIN_EVERY  = 250;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          CYCLE_LIMIT  = 400000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;

  int mismatch_count;
  int outstanding;
  int cycle_count      = 0;
  int burst_left       = 0;
  bit sender_steady    = 1'b0;
  bit receiver_steady  = 1'b0;
  bit hold_request     = 1'b0;

  always #5 clk_i = ~clk_i;

  gregorian_hours_between_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  elapsed_hours_checker scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tdata_i        (s_axis_tdata),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // Pack one moment, year in the lowest bits
  function automatic logic [MOMENT_W-1:0] pack_moment(input int unsigned y, mo, d, h);
    return {HOUR_W'(h), DAY_W'(d), MONTH_W'(mo), YEAR_W'(y)};
  endfunction

  // Ordering key: year, month, day, hour from the top down
  function automatic logic [MOMENT_W-1:0] order_key(input int unsigned y, mo, d, h);
    return {YEAR_W'(y), MONTH_W'(mo), DAY_W'(d), HOUR_W'(h)};
  endfunction

  // Offer one date pair and hold it until the transaction completes
  task automatic offer_pair(input logic [MOMENT_W-1:0] first, second);
    int gap;
    gap = (sender_steady || burst_left > 0) ? 0 : $urandom_range(0, 14);
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {{(IN_TDATA_W - 2 * MOMENT_W){1'b0}}, second, first};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic await_empty();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gregorian_hours_between_unit verification failed");
      $finish;
    end
  end

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int wait_cycles;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_steady = !receiver_steady;
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        wait_cycles = receiver_steady ? 0 : $urandom_range(0, 14);
        if (wait_cycles > 0) begin
          m_axis_tready <= 1'b0;
          repeat (wait_cycles) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
        while (!m_axis_tvalid) @(posedge clk_i);
      end
    end
  end

  // Input side and verdict
  initial begin
    int unsigned         sy, sm, sd, sh, ey, em, ed, eh, kind;
    logic [MOMENT_W-1:0] first, second, spare;
    bit                  want_order, want_reverse;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero span, a full day, and an hour-only reversal
    offer_pair(pack_moment(2024, 1, 1, 0), pack_moment(2024, 1, 1, 0));
    offer_pair(pack_moment(2024, 6, 15, 0), pack_moment(2024, 6, 15, DAY_FULL));
    offer_pair(pack_moment(2024, 6, 15, 4096), pack_moment(2024, 6, 15, 0));
    // Widest span and the year, month and day reversals
    offer_pair(pack_moment(0, 1, 1, 0), pack_moment(YEAR_MAX, 12, 31, HOUR_MAX));
    offer_pair(pack_moment(YEAR_MAX, 12, 31, HOUR_MAX), pack_moment(0, 1, 1, 0));
    offer_pair(pack_moment(2000, 5, 1, 0), pack_moment(2000, 4, 30, 0));
    offer_pair(pack_moment(2000, 5, 2, 0), pack_moment(2000, 5, 1, 0));
    // February across the leap rules, year zero included
    offer_pair(pack_moment(2000, 2, 28, 0), pack_moment(2000, 3, 1, 0));
    offer_pair(pack_moment(1900, 2, 28, 0), pack_moment(1900, 3, 1, 0));
    offer_pair(pack_moment(2024, 2, 28, 2048), pack_moment(2024, 3, 1, 0));
    offer_pair(pack_moment(2023, 2, 28, 0), pack_moment(2023, 3, 1, 0));
    offer_pair(pack_moment(0, 2, 28, 0), pack_moment(0, 3, 1, 0));
    offer_pair(pack_moment(0, 12, 31, 0), pack_moment(1, 1, 1, 0));
    offer_pair(pack_moment(2100, 2, 29, 0), pack_moment(2100, 3, 1, 0));
    // Months outside the calendar clamp to January or December
    offer_pair(pack_moment(2010, 0, 5, 0), pack_moment(2010, 1, 5, 100));
    offer_pair(pack_moment(2010, 13, 5, 0), pack_moment(2010, 12, 5, 0));
    offer_pair(pack_moment(2010, 15, 1, 0), pack_moment(2011, 0, 1, 0));
    // Invalid days and oversized hours, negative difference among them
    offer_pair(pack_moment(2021, 4, 31, 4096), pack_moment(2021, 5, 1, 0));
    offer_pair(pack_moment(2021, 4, 31, 0), pack_moment(2021, 5, 1, 0));
    offer_pair(pack_moment(2021, 3, 0, 0), pack_moment(2021, 3, 1, 0));
    offer_pair(pack_moment(2021, 3, 1, HOUR_MAX), pack_moment(2021, 3, 2, 0));
    offer_pair(pack_moment(2021, 3, 1, HOUR_MAX), pack_moment(2021, 3, 3, 0));
    // All-ones fields
    offer_pair(pack_moment(YEAR_MAX, 15, 31, HOUR_MAX), pack_moment(YEAR_MAX, 15, 31, HOUR_MAX));
    offer_pair(pack_moment(1, 1, 1, 0), pack_moment(YEAR_MAX, 15, 31, HOUR_MAX));
    await_empty();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > 0 && n % DRAIN_EVERY == 0) await_empty();
      if (n == HOLD_AT) begin
        hold_request = 1'b1;
        burst_left   = HOLD_BURST;
      end
      if ($urandom_range(0, 49) == 0) sender_steady = !sender_steady;

      // Start from a well-formed pair, then bend it per item kind
      kind = $urandom_range(0, 15);
      sy = $urandom_range(0, YEAR_MAX);
      sm = $urandom_range(1, 12);
      sd = $urandom_range(1, 28);
      sh = $urandom_range(0, DAY_FULL);
      ey = $urandom_range(0, YEAR_MAX);
      em = $urandom_range(1, 12);
      ed = $urandom_range(1, 28);
      eh = $urandom_range(0, DAY_FULL);
      case (kind)
        0, 1, 2, 3, 4, 5, 6, 7: begin
          ey = $urandom_range(0, 1) ? sy + $urandom_range(0, 3) : $urandom_range(sy, YEAR_MAX);
        end
        8: begin
          ey = sy;
          em = sm;
          ed = sd;
          sh = $urandom_range(0, HOUR_MAX);
          eh = $urandom_range(0, HOUR_MAX);
        end
        9: begin
          ey = sy;
          em = sm;
        end
        10, 11: begin
          sm = $urandom_range(0, 15);
          sd = $urandom_range(0, 31);
          sh = $urandom_range(0, HOUR_MAX);
          em = $urandom_range(0, 15);
          ed = $urandom_range(0, 31);
          eh = $urandom_range(0, HOUR_MAX);
        end
        12: begin
          ey = sy + $urandom_range(0, 2);
        end
        13: begin
          sy = $urandom_range(0, 40) * 100 + $urandom_range(0, 1) * $urandom_range(0, 7);
          sm = 2;
          sd = $urandom_range(28, 29);
          ey = sy + $urandom_range(0, 1);
          em = 3;
          ed = 1;
        end
        14: begin
          ey = sy;
          sm = $urandom_range(1, 11);
          em = sm + 1;
          sd = $urandom_range(29, 31);
          ed = $urandom_range(0, 2);
          sh = $urandom_range(0, HOUR_MAX);
        end
        default: begin
          sm = $urandom_range(0, 3);
          if (sm != 0) sm += 12;
          em = $urandom_range(0, 15);
          ey = sy + $urandom_range(0, 1);
          sd = $urandom_range(0, 31);
          ed = $urandom_range(0, 31);
        end
      endcase
      if (ey > YEAR_MAX) ey = YEAR_MAX;

      first  = pack_moment(sy, sm, sd, sh);
      second = pack_moment(ey, em, ed, eh);
      want_order   = (kind <= 7) || kind == 9 || kind == 13;
      want_reverse = (kind == 12);
      // Put the pair in the order its kind calls for
      if ((want_order && order_key(sy, sm, sd, sh) > order_key(ey, em, ed, eh)) ||
          (want_reverse && order_key(sy, sm, sd, sh) < order_key(ey, em, ed, eh))) begin
        spare  = first;
        first  = second;
        second = spare;
      end
      offer_pair(first, second);
    end

    await_empty();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("gregorian_hours_between_unit verification clean");
    end else begin
      $display("gregorian_hours_between_unit verification failed");
    end
    $finish;
  end

endmodule
